// ===== rtl/ibmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// ibmtf_pkg: shared definitions for the identifier binding table
// Opcodes, status codes, activation states, default sizes and the control
// bundle that the top level sends to every table cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ibmtf_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int KEY_BYTES_DEF = 8;

    // Field widths of the channels
    localparam int OPCODE_W = 2;
    localparam int KEY_IN_W = 64;
    localparam int LEN_W    = 4;
    localparam int ACT_W    = 2;
    localparam int SLOT_W   = 3;
    localparam int STATUS_W = 3;

    // Operations
    localparam logic [OPCODE_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_ACK   = 2'd3;

    // Activation states; only activation and retrofit allow a rematch.
    localparam logic [ACT_W-1:0] ACT_SIG_FAIL   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACTIVATION = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RETROFIT   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_OTHER      = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PASS      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NN        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OBD       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OBT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNMATCH   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd6;

    // Per-cell control: clear wins over write, write over shift.
    typedef struct packed {
        logic compare;
        logic clear;
        logic write;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ibmtf_if.sv =====
// ----------------------------------------------------------------------------
// ibmtf_if: channel interfaces of the identifier binding table
// Request, response and configuration channels, each with valid/ready and
// its payload, seen from a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibmtf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] key_bytes;
    logic [3:0]  key_len;
    logic [1:0]  boot_state;
    logic        battery_spare;
    logic        batt_rematch;
    logic [2:0]  entry_index;
    logic        load_version_current;

    modport source (
        output valid, opcode, key_bytes, key_len, boot_state, battery_spare,
               batt_rematch, entry_index, load_version_current,
        input  ready
    );
    modport sink (
        input  valid, opcode, key_bytes, key_len, boot_state, battery_spare,
               batt_rematch, entry_index, load_version_current,
        output ready
    );
endinterface

interface ibmtf_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] hit_index;
    logic       update_pending;

    modport source (
        output valid, status, hit_index, update_pending,
        input  ready
    );
    modport sink (
        input  valid, status, hit_index, update_pending,
        output ready
    );
endinterface

interface ibmtf_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ibmtf_cell.sv =====
// ----------------------------------------------------------------------------
// ibmtf_cell: one slot of the binding table
// Holds one key, takes its upper neighbor's key on a shift, and registers
// the result of a masked compare against the broadcast key.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmtf_cell #(
    parameter int KEY_W = 64
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ibmtf_pkg::cell_ctl_t ctl,
    input  wire [KEY_W-1:0]      wr_data,
    input  wire [KEY_W-1:0]      prev_key,
    input  wire [KEY_W-1:0]      cmp_key,
    input  wire [KEY_W-1:0]      cmp_mask,
    output logic [KEY_W-1:0]     key,
    output logic                 match
);
    import ibmtf_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic             match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
                key_reg <= '0;
            else if (ctl.write)
                key_reg <= wr_data;
            else if (ctl.shift)
                key_reg <= prev_key;

            if (ctl.compare)
                match_reg <= ((key_reg ^ cmp_key) & cmp_mask) == '0;
        end
    end

    assign key   = key_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/id_binding_move_to_front_table.sv =====
// ----------------------------------------------------------------------------
// id_binding_move_to_front_table: move-to-front table of bound identifiers
// Checks keys against a most-recent-first table of cells and keeps it up to
// date, with clear, load and write-back acknowledge operations.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req channel and each one gives exactly one result on
// the rsp channel; a transfer happens on a clock edge where valid and ready
// are both high. The cfg channel writes board_is_new and is always ready;
// write it only while no item is in flight.
// An item passes the accept edge, a compare step in which every cell
// registers its masked compare, and a decide step in which the first hit is
// picked and the row of cells shifts or loads. The result is registered as
// the decide step ends, and req.ready returns in the same cycle in which the
// result becomes valid, so a new item is taken only once the last one has
// been decided; the compare register in the cells and the decide step set that pace.
// The result sits in an output register; while rsp.ready is low a new item
// can still be accepted and compared, and its decide step waits until the
// held result has been transferred.
// Reset clears all slots to zero, marks the version current, clears the
// write-back flag and sets board_is_new. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module id_binding_move_to_front_table #(
    parameter int ENTRIES   = ibmtf_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES = ibmtf_pkg::KEY_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    ibmtf_req_if.sink   req,
    ibmtf_rsp_if.source rsp,
    ibmtf_cfg_if.sink   cfg
);
    import ibmtf_pkg::*;

    localparam int KEY_W = KEY_BYTES * 8;
    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DECIDE
    } state_t;

    state_t state_reg;

    // Captured item
    logic [OPCODE_W-1:0] op_reg;
    logic [KEY_IN_W-1:0] key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [ACT_W-1:0]    act_reg;
    logic                spare_reg;
    logic                remat_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic                lvc_reg;

    logic ver_reg;
    logic wbp_reg;
    logic board_new_reg;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   hit_reg;
    logic                upd_reg;

    // Cell row
    logic [KEY_W-1:0] keys [ENTRIES];
    logic [KEY_W-1:0] prev [ENTRIES];
    logic [ENTRIES-1:0] match_vec;
    cell_ctl_t          ctl [ENTRIES];

    logic [KEY_W-1:0]    mask;
    logic [KEY_W-1:0]    wr_data;
    logic                ignored;
    logic                any_hit;
    logic [IDX_W-1:0]    hit_pos;
    logic [KEY_W-1:0]    sel;
    logic                out_free;
    logic                commit;
    logic                miss_bit;
    logic [STATUS_W-1:0] status_next;
    logic [SLOT_W-1:0]   hit_next;
    logic                ver_next;
    logic                wbp_next;

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign commit   = (state_reg == S_DECIDE) && out_free;

    always_comb
    begin
        for (int b = 0; b < KEY_BYTES; b++)
            mask[b*8 +: 8] = {8{int'(len_reg) > b}};
        ignored = int'(len_reg) > KEY_BYTES;

        // The first matching slot wins.
        any_hit = 1'b0;
        hit_pos = '0;
        for (int k = ENTRIES - 1; k >= 0; k--)
        begin
            if (match_vec[k])
            begin
                any_hit = 1'b1;
                hit_pos = IDX_W'(k);
            end
        end
        sel = keys[hit_pos];

        prev[0] = '0;
        for (int k = 1; k < ENTRIES; k++)
            prev[k] = keys[k-1];
    end

    always_comb
    begin
        status_next = ST_UNCHANGED;
        hit_next    = '0;
        ver_next    = ver_reg;
        wbp_next    = wbp_reg;
        wr_data     = '0;
        miss_bit    = (act_reg == ACT_ACTIVATION) ? spare_reg : remat_reg;
        for (int k = 0; k < ENTRIES; k++)
            ctl[k] = '0;

        unique case (op_reg)
            OP_CHECK:
            begin
                if (ignored)
                    status_next = ST_IGNORED;
                else if (any_hit)
                begin
                    status_next = ST_PASS;
                    hit_next    = SLOT_W'(hit_pos);
                    if (hit_pos != '0 || !ver_reg)
                    begin
                        // Move the hit entry to the head.
                        ver_next      = 1'b1;
                        wbp_next      = 1'b1;
                        wr_data       = sel;
                        ctl[0].write = 1'b1;
                        for (int k = 1; k < ENTRIES; k++)
                            ctl[k].shift = IDX_W'(k) <= hit_pos;
                    end
                end
                else if (act_reg == ACT_ACTIVATION || act_reg == ACT_RETROFIT)
                begin
                    if (miss_bit && board_new_reg)
                        status_next = ST_NN;
                    else if (miss_bit)
                        status_next = ST_OBD;
                    else if (board_new_reg)
                        status_next = ST_OBT;
                    else
                        status_next = ST_UNMATCH;

                    if (miss_bit || board_new_reg)
                    begin
                        // Rematch: push the row down and merge the key bytes
                        // into the old head value.
                        ver_next      = 1'b1;
                        wbp_next      = 1'b1;
                        wr_data       = (keys[0] & ~mask) | (key_reg[KEY_W-1:0] & mask);
                        ctl[0].write = 1'b1;
                        for (int k = 1; k < ENTRIES; k++)
                            ctl[k].shift = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                ver_next = 1'b1;
                wbp_next = 1'b1;
                for (int k = 0; k < ENTRIES; k++)
                    ctl[k].clear = 1'b1;
            end
            OP_LOAD:
            begin
                if (int'(idx_reg) < ENTRIES)
                begin
                    wr_data = key_reg[KEY_W-1:0];
                    for (int k = 0; k < ENTRIES; k++)
                        ctl[k].write = int'(idx_reg) == k;
                    if (idx_reg == '0)
                        ver_next = lvc_reg;
                end
            end
            OP_ACK:
            begin
                wbp_next = 1'b0;
            end
            default:
            begin
                status_next = ST_UNCHANGED;
            end
        endcase

        for (int k = 0; k < ENTRIES; k++)
        begin
            ctl[k].clear   = ctl[k].clear & commit;
            ctl[k].write   = ctl[k].write & commit;
            ctl[k].shift   = ctl[k].shift & commit;
            ctl[k].compare = state_reg == S_CMP;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        ibmtf_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[g]),
            .wr_data  (wr_data),
            .prev_key (prev[g]),
            .cmp_key  (key_reg[KEY_W-1:0]),
            .cmp_mask (mask),
            .key      (keys[g]),
            .match    (match_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ver_reg       <= 1'b1;
            wbp_reg       <= 1'b0;
            board_new_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_UNCHANGED;
            hit_reg       <= '0;
            upd_reg       <= 1'b0;
            op_reg        <= OP_CHECK;
            key_reg       <= '0;
            len_reg       <= '0;
            act_reg       <= ACT_SIG_FAIL;
            spare_reg     <= 1'b0;
            remat_reg     <= 1'b0;
            idx_reg       <= '0;
            lvc_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                board_new_reg <= cfg.data;

            // A new result takes the output register in the cycle it frees.
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= req.opcode;
                        key_reg   <= req.key_bytes;
                        len_reg   <= req.key_len;
                        act_reg   <= req.boot_state;
                        spare_reg <= req.battery_spare;
                        remat_reg <= req.batt_rematch;
                        idx_reg   <= req.entry_index;
                        lvc_reg   <= req.load_version_current;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        ver_reg    <= ver_next;
                        wbp_reg    <= wbp_next;
                        status_reg <= status_next;
                        hit_reg    <= hit_next;
                        upd_reg    <= wbp_next;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready          = state_reg == S_IDLE;
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.hit_index      = hit_reg;
    assign rsp.update_pending = upd_reg;

`ifndef SYNTHESIS
    // A move to front leaves the hit entry at the head.
    a_move_to_head: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && op_reg == OP_CHECK && !ignored && any_hit
            && (hit_pos != '0 || !ver_reg))
        |=> keys[0] == $past(sel))
        else $error("hit entry not moved to the head");

    // The reported write-back flag is the one the table now holds.
    a_update_flag: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp.valid && rsp.update_pending == wbp_reg)
        else $error("update_pending disagrees with the write-back flag");

    // A clear empties both ends of the row.
    a_clear_row: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && op_reg == OP_CLEAR)
        |=> keys[0] == '0 && keys[ENTRIES-1] == '0 && ver_reg)
        else $error("clear left a slot or the version stale");
`endif

endmodule

`default_nettype wire
